/* rtl/core/nmea_sentence_field_parser_top_defines.svh */
// ----------------------------------------------------------------------------
// NMEA sentence field parser assertion macros
// Shared helpers for the concurrent checks in the parser's modules.
// ----------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_FIELD_PARSER_TOP_DEFINES_SVH
`define NMEA_SENTENCE_FIELD_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NSFP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NSFP_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/nsfp_pkg.sv */
// ----------------------------------------------------------------------------
// NMEA sentence field parser package
// Types shared by the front classifier, the beat queue and the field engine.
// ----------------------------------------------------------------------------
`default_nettype none

package nsfp_pkg;

    typedef enum logic [3:0] {
        LET_V,
        LET_T,
        LET_G,
        LET_R,
        LET_M,
        LET_C,
        LET_S,
        LET_A,
        LET_OTHER
    } letter_t;

    typedef struct packed {
        logic [7:0] data;
        logic [3:0] digit;
        logic       is_digit;
        logic       is_dot;
        logic       is_comma;
        logic       is_star;
        letter_t    letter;
        logic       start;
        logic       last;
    } item_t;

endpackage

`default_nettype wire

/* rtl/core/nmea_sentence_field_parser_top.sv */
// ----------------------------------------------------------------------------
// NMEA sentence field parser
// Splits GPS sentences into fields and returns each field's decimal value.
// ----------------------------------------------------------------------------
// Input beats carry one sentence character on s_data_byte, with
// s_sentence_start on the first character and s_sentence_end on the last.
// VTG, RMC, GSA and GGA sentences are recognised from the sentence name; the
// fields that follow the name are returned one beat per field on the m_
// channel, with the mantissa, the fraction digit count and the flags.
// A character beat is classified on entry, held in a two-entry queue and
// then consumed by the field engine, which registers the result.
// Throughput is one character per cycle unless a result waits on m_ready;
// a result is registered as the field engine pops the character closing its field.
// When m_ready is low the result register holds and the queue fills;
// s_ready falls once both queue entries are occupied.
// Reset clears the queue, the result valid flag and the sentence state, so
// the next character is taken as the first of a sentence.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_sentence_field_parser_top #(
    parameter int FIELD_CHARS = 9
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_sentence_start,
    input  wire logic        s_sentence_end,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_sentence_type,
    output logic [4:0]       m_field_index,
    output logic             m_is_empty,
    output logic [29:0]      m_digit_value,
    output logic [3:0]       m_frac_digits,
    output logic [7:0]       m_field_char,
    output logic             m_overflow,
    output logic             m_final_field
);

    logic            queue_full;
    logic            push;
    nsfp_pkg::item_t push_item;
    logic            pop;
    logic            head_valid;
    nsfp_pkg::item_t head_item;

    nsfp_front u_front (
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_sentence_start (s_sentence_start),
        .s_sentence_end   (s_sentence_end),
        .queue_full       (queue_full),
        .push             (push),
        .push_item        (push_item)
    );

    nsfp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    nsfp_back #(
        .FIELD_CHARS (FIELD_CHARS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head_valid      (head_valid),
        .head_item       (head_item),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sentence_type (m_sentence_type),
        .m_field_index   (m_field_index),
        .m_is_empty      (m_is_empty),
        .m_digit_value   (m_digit_value),
        .m_frac_digits   (m_frac_digits),
        .m_field_char    (m_field_char),
        .m_overflow      (m_overflow),
        .m_final_field   (m_final_field)
    );

endmodule

`default_nettype wire

/* rtl/core/nsfp_front.sv */
// ----------------------------------------------------------------------------
// NMEA sentence field parser front end
// Accepts input beats and classifies each character before it is queued.
// ----------------------------------------------------------------------------
`default_nettype none

module nsfp_front (
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic [7:0]     s_data_byte,
    input  wire logic           s_sentence_start,
    input  wire logic           s_sentence_end,
    input  wire logic           queue_full,
    output logic                push,
    output nsfp_pkg::item_t     push_item
);

    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    logic [7:0] offset;

    assign s_ready = !queue_full;
    assign push    = s_valid && !queue_full;
    assign offset  = s_data_byte - CHAR_ZERO;

    always_comb begin
        push_item.data     = s_data_byte;
        push_item.digit    = offset[3:0];
        push_item.is_digit = (s_data_byte >= CHAR_ZERO) && (s_data_byte <= CHAR_NINE);
        push_item.is_dot   = (s_data_byte == CHAR_DOT);
        push_item.is_comma = (s_data_byte == CHAR_COMMA);
        push_item.is_star  = (s_data_byte == CHAR_STAR);
        push_item.start    = s_sentence_start;
        push_item.last     = s_sentence_end;
        unique case (s_data_byte)
            8'h56:   push_item.letter = nsfp_pkg::LET_V;
            8'h54:   push_item.letter = nsfp_pkg::LET_T;
            8'h47:   push_item.letter = nsfp_pkg::LET_G;
            8'h52:   push_item.letter = nsfp_pkg::LET_R;
            8'h4D:   push_item.letter = nsfp_pkg::LET_M;
            8'h43:   push_item.letter = nsfp_pkg::LET_C;
            8'h53:   push_item.letter = nsfp_pkg::LET_S;
            8'h41:   push_item.letter = nsfp_pkg::LET_A;
            default: push_item.letter = nsfp_pkg::LET_OTHER;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/nsfp_queue.sv */
// ----------------------------------------------------------------------------
// NMEA sentence field parser beat queue
// Two-entry queue that decouples the front end from the field engine.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nmea_sentence_field_parser_top_defines.svh"

module nsfp_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire nsfp_pkg::item_t  push_item,
    output logic                  full,
    input  wire logic             pop,
    output logic                  head_valid,
    output nsfp_pkg::item_t       head_item
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    nsfp_pkg::item_t mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    `NSFP_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(DEPTH), "queue overfull")
    `NSFP_ASSERT_NOW(a_no_pop_empty, aclk, aresetn, pop, count_reg != '0, "pop from empty queue")
    `NSFP_ASSERT_NXT(a_count_track, aclk, aresetn, push && !pop, count_reg == CW'($past(count_reg) + 1'b1), "queue count lost a beat")

endmodule

`default_nettype wire

/* rtl/core/nsfp_back.sv */
// ----------------------------------------------------------------------------
// NMEA sentence field parser field engine
// Tracks sentence type and field state and registers one result per data field of a recognised sentence.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nmea_sentence_field_parser_top_defines.svh"

module nsfp_back #(
    parameter int FIELD_CHARS = 9
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             head_valid,
    input  wire nsfp_pkg::item_t  head_item,
    output logic                  pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [1:0]            m_sentence_type,
    output logic [4:0]            m_field_index,
    output logic                  m_is_empty,
    output logic [29:0]           m_digit_value,
    output logic [3:0]            m_frac_digits,
    output logic [7:0]            m_field_char,
    output logic                  m_overflow,
    output logic                  m_final_field
);

    localparam int          CW           = $clog2(FIELD_CHARS + 1);
    localparam logic [29:0] MANTISSA_MAX = 30'd999999999;

    typedef enum logic [2:0] {
        KIND_VTG     = 3'd0,
        KIND_RMC     = 3'd1,
        KIND_GSA     = 3'd2,
        KIND_GGA     = 3'd3,
        KIND_UNKNOWN = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_INT,
        PH_FRAC,
        PH_DONE
    } phase_t;

    function automatic logic [4:0] kind_fields(input kind_t k);
        logic [4:0] n;
        begin
            unique case (k)
                KIND_VTG: n = 5'd9;
                KIND_RMC: n = 5'd8;
                KIND_GSA: n = 5'd17;
                KIND_GGA: n = 5'd12;
                default:  n = 5'd0;
            endcase
            return n;
        end
    endfunction

    logic [2:0]    pos_reg, pos_next;
    kind_t         kind_reg, kind_next;
    logic [4:0]    fcnt_reg, fcnt_next;
    logic [29:0]   acc_reg, acc_next;
    logic [3:0]    frac_reg, frac_next;
    phase_t        phase_reg, phase_next;
    logic [CW-1:0] ccnt_reg, ccnt_next;
    logic [7:0]    char_reg, char_next;
    logic          star_reg, star_next;
    logic          long_reg, long_next;
    logic          valid_reg, valid_next;

    logic [1:0]    type_reg;
    logic [4:0]    index_reg;
    logic          empty_reg;
    logic [29:0]   value_reg;
    logic [3:0]    fdig_reg;
    logic [7:0]    fchar_reg;
    logic          ovf_reg;
    logic          final_reg;

    logic [2:0]    b_pos;
    kind_t         b_kind;
    logic [4:0]    b_fcnt;
    logic [29:0]   b_acc;
    logic [3:0]    b_frac;
    phase_t        b_phase;
    logic [CW-1:0] b_ccnt;
    logic [7:0]    b_char;
    logic          b_star;
    logic          b_long;

    kind_t         k_new;
    logic [29:0]   f_acc;
    logic [3:0]    f_frac;
    phase_t        f_phase;
    logic [CW-1:0] f_ccnt;
    logic [7:0]    f_char;
    logic          f_long;
    logic [33:0]   acc_x10;
    logic          add_ovf;
    logic          do_add;
    logic          add_frac;
    logic          is_term;
    logic          ends;
    logic          emit;
    logic [4:0]    idx;

    assign pop = head_valid && (!valid_reg || m_ready);

    always_comb begin
        b_pos   = head_item.start ? 3'd0 : pos_reg;
        b_kind  = head_item.start ? KIND_UNKNOWN : kind_reg;
        b_fcnt  = head_item.start ? 5'd0 : fcnt_reg;
        b_acc   = head_item.start ? 30'd0 : acc_reg;
        b_frac  = head_item.start ? 4'd0 : frac_reg;
        b_phase = head_item.start ? PH_SKIP : phase_reg;
        b_ccnt  = head_item.start ? '0 : ccnt_reg;
        b_char  = head_item.start ? 8'd0 : char_reg;
        b_star  = head_item.start ? 1'b0 : star_reg;
        b_long  = head_item.start ? 1'b0 : long_reg;

        k_new = b_kind;
        case (b_pos)
            3'd3: begin
                if (head_item.letter == nsfp_pkg::LET_V) begin
                    k_new = KIND_VTG;
                end else if (head_item.letter == nsfp_pkg::LET_R) begin
                    k_new = KIND_RMC;
                end else if (head_item.letter == nsfp_pkg::LET_G) begin
                    k_new = KIND_GSA;
                end else begin
                    k_new = KIND_UNKNOWN;
                end
            end
            3'd4: begin
                if (b_kind == KIND_VTG && head_item.letter == nsfp_pkg::LET_T) begin
                    k_new = KIND_VTG;
                end else if (b_kind == KIND_RMC && head_item.letter == nsfp_pkg::LET_M) begin
                    k_new = KIND_RMC;
                end else if (b_kind == KIND_GSA && head_item.letter == nsfp_pkg::LET_S) begin
                    k_new = KIND_GSA;
                end else if (b_kind == KIND_GSA && head_item.letter == nsfp_pkg::LET_G) begin
                    k_new = KIND_GGA;
                end else begin
                    k_new = KIND_UNKNOWN;
                end
            end
            3'd5: begin
                if (b_kind == KIND_VTG && head_item.letter == nsfp_pkg::LET_G) begin
                    k_new = KIND_VTG;
                end else if (b_kind == KIND_RMC && head_item.letter == nsfp_pkg::LET_C) begin
                    k_new = KIND_RMC;
                end else if ((b_kind == KIND_GSA || b_kind == KIND_GGA)
                             && head_item.letter == nsfp_pkg::LET_A) begin
                    k_new = b_kind;
                end else begin
                    k_new = KIND_UNKNOWN;
                end
            end
            default: k_new = b_kind;
        endcase

        acc_x10 = {b_acc, 3'b000} + {3'b000, b_acc, 1'b0} + {30'd0, head_item.digit};
        add_ovf = (acc_x10 > {4'd0, MANTISSA_MAX});
        is_term = head_item.is_comma || head_item.is_star;

        f_acc    = b_acc;
        f_frac   = b_frac;
        f_phase  = b_phase;
        f_ccnt   = b_ccnt;
        f_char   = b_char;
        f_long   = b_long;
        do_add   = 1'b0;
        add_frac = 1'b0;
        if (!b_star && !is_term) begin
            if (b_ccnt >= CW'(FIELD_CHARS)) begin
                f_long = 1'b1;
            end else begin
                f_ccnt = b_ccnt + 1'b1;
                f_char = head_item.data;
                unique case (b_phase)
                    PH_SKIP: begin
                        if (head_item.is_digit) begin
                            f_phase = PH_INT;
                            do_add  = 1'b1;
                        end
                    end
                    PH_INT: begin
                        if (head_item.is_digit) begin
                            do_add = 1'b1;
                        end else if (head_item.is_dot) begin
                            f_phase = PH_FRAC;
                        end else begin
                            f_phase = PH_DONE;
                        end
                    end
                    PH_FRAC: begin
                        if (head_item.is_digit) begin
                            do_add   = 1'b1;
                            add_frac = 1'b1;
                        end else begin
                            f_phase = PH_DONE;
                        end
                    end
                    default: f_phase = b_phase;
                endcase
                if (do_add) begin
                    if (add_ovf) begin
                        f_acc   = MANTISSA_MAX;
                        f_long  = 1'b1;
                        f_phase = PH_DONE;
                    end else begin
                        f_acc = acc_x10[29:0];
                        if (add_frac && b_frac != 4'd15) begin
                            f_frac = b_frac + 1'b1;
                        end
                    end
                end
            end
        end

        ends = !b_star && (is_term || head_item.last);
        idx  = b_fcnt - 5'd1;
        emit = ends && (b_fcnt != 5'd0) && (k_new != KIND_UNKNOWN) && (b_pos >= 3'd5)
               && (idx < kind_fields(k_new));

        pos_next   = (b_pos == 3'd7) ? 3'd7 : b_pos + 1'b1;
        kind_next  = k_new;
        fcnt_next  = b_fcnt;
        acc_next   = f_acc;
        frac_next  = f_frac;
        phase_next = f_phase;
        ccnt_next  = f_ccnt;
        char_next  = f_char;
        star_next  = b_star;
        long_next  = f_long;
        if (ends) begin
            fcnt_next  = (b_fcnt == 5'd31) ? 5'd31 : b_fcnt + 1'b1;
            acc_next   = 30'd0;
            frac_next  = 4'd0;
            phase_next = PH_SKIP;
            ccnt_next  = '0;
            char_next  = 8'd0;
            long_next  = 1'b0;
            star_next  = head_item.is_star;
        end
        if (head_item.last) begin
            pos_next   = 3'd0;
            kind_next  = KIND_UNKNOWN;
            fcnt_next  = 5'd0;
            acc_next   = 30'd0;
            frac_next  = 4'd0;
            phase_next = PH_SKIP;
            ccnt_next  = '0;
            char_next  = 8'd0;
            star_next  = 1'b0;
            long_next  = 1'b0;
        end

        valid_next = valid_reg && !m_ready;
        if (pop && emit) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= 3'd0;
            kind_reg  <= KIND_UNKNOWN;
            fcnt_reg  <= 5'd0;
            acc_reg   <= 30'd0;
            frac_reg  <= 4'd0;
            phase_reg <= PH_SKIP;
            ccnt_reg  <= '0;
            char_reg  <= 8'd0;
            star_reg  <= 1'b0;
            long_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (pop) begin
                pos_reg   <= pos_next;
                kind_reg  <= kind_next;
                fcnt_reg  <= fcnt_next;
                acc_reg   <= acc_next;
                frac_reg  <= frac_next;
                phase_reg <= phase_next;
                ccnt_reg  <= ccnt_next;
                char_reg  <= char_next;
                star_reg  <= star_next;
                long_reg  <= long_next;
            end
        end
        if (pop && emit) begin
            type_reg  <= k_new[1:0];
            index_reg <= idx;
            empty_reg <= (f_ccnt == '0);
            value_reg <= f_acc;
            fdig_reg  <= f_frac;
            fchar_reg <= f_char;
            ovf_reg   <= f_long;
            final_reg <= head_item.last || head_item.is_star;
        end
    end

    assign m_valid         = valid_reg;
    assign m_sentence_type = type_reg;
    assign m_field_index   = index_reg;
    assign m_is_empty      = empty_reg;
    assign m_digit_value   = value_reg;
    assign m_frac_digits   = fdig_reg;
    assign m_field_char    = fchar_reg;
    assign m_overflow      = ovf_reg;
    assign m_final_field   = final_reg;

    `NSFP_ASSERT_NOW(a_empty_zero, aclk, aresetn, valid_reg && empty_reg, value_reg == 30'd0 && fchar_reg == 8'd0 && fdig_reg == 4'd0, "empty field carries data")
    `NSFP_ASSERT_NOW(a_index_range, aclk, aresetn, valid_reg, index_reg < kind_fields(kind_t'({1'b0, type_reg})), "field index beyond type count")
    `NSFP_ASSERT_NOW(a_mantissa_range, aclk, aresetn, 1'b1, acc_reg <= MANTISSA_MAX, "mantissa above limit")

endmodule

`default_nettype wire
